// ----- hdl/assert_macros.svh -----
// Concurrent assertion helpers; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/brbf_pkg.sv -----
package brbf_pkg;

   localparam int DEPTH_DEF  = 256;
   localparam int LANES_DEF  = 8;

   localparam int ACTION_W   = 2;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = 64;
   localparam int STAT_W     = 8;
   localparam int RING_CFG_W = 9;
   localparam int RING_RESET = 256;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } bank_op_type;

endpackage

// ----- hdl/brbf_if.sv -----
interface brbf_req_if import brbf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [LEN_W-1:0]    length;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, output action, output length, output write_data,
                   input ready);
   modport sink   (input valid, input action, input length, input write_data,
                   output ready);
endinterface

interface brbf_rsp_if import brbf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LEN_W-1:0]  count;
   logic [DATA_W-1:0] read_data;
   logic [STAT_W-1:0] fill_level;
   logic [STAT_W-1:0] free_space;
   logic [STAT_W-1:0] read_position;
   logic [STAT_W-1:0] read_run;
   logic [STAT_W-1:0] write_position;
   logic [STAT_W-1:0] write_run;

   modport source (output valid, output count, output read_data, output fill_level,
                   output free_space, output read_position, output read_run,
                   output write_position, output write_run, input ready);
   modport sink   (input valid, input count, input read_data, input fill_level,
                   input free_space, input read_position, input read_run,
                   input write_position, input write_run, output ready);
endinterface

// ----- hdl/brbf_bank.sv -----
module brbf_bank import brbf_pkg::*; #(
   parameter int LANES = LANES_DEF,
   parameter int ROWS  = DEPTH_DEF / LANES_DEF,
   parameter int BANK  = 0
) (
   input  logic                                          clock,
   input  bank_op_type                                   op,
   input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0]  wr_bank,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0]    wr_row,
   input  logic [LEN_W-1:0]                              wr_len,
   input  logic [LANES-1:0][7:0]                         wr_data,
   input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0]  rd_bank,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0]    rd_row,
   output logic [7:0]                                    rd_data
);

   localparam int BW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [7:0]    store_ff [ROWS];
   logic [7:0]    rd_data_ff;
   logic [BW:0]   wr_wrap;
   logic [BW-1:0] wr_lane;
   logic [RW-1:0] wr_row_next;
   logic [RW-1:0] wr_addr;
   logic          wr_hit;
   logic [RW-1:0] rd_row_next;
   logic [RW-1:0] rd_addr;

   assign wr_wrap     = (BW+1)'(BANK) + (BW+1)'(LANES) - {1'b0, wr_bank};
   assign wr_lane     = (BW'(BANK) >= wr_bank) ? BW'(BANK) - wr_bank : wr_wrap[BW-1:0];
   assign wr_row_next = (wr_row == RW'(ROWS - 1)) ? '0 : wr_row + 1'b1;
   assign wr_addr     = (BW'(BANK) < wr_bank) ? wr_row_next : wr_row;
   assign wr_hit      = op.wr_en && (LEN_W'(wr_lane) < wr_len);

   assign rd_row_next = (rd_row == RW'(ROWS - 1)) ? '0 : rd_row + 1'b1;
   assign rd_addr     = (BW'(BANK) < rd_bank) ? rd_row_next : rd_row;

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         store_ff[wr_addr] <= wr_data[wr_lane];
      end
      if (op.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/brbf_merge.sv -----
module brbf_merge import brbf_pkg::*; #(
   parameter int LANES = LANES_DEF
) (
   input  logic [LANES-1:0][7:0]                         bank_data,
   input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0]  rot,
   input  logic [LEN_W-1:0]                              cnt,
   output logic [DATA_W-1:0]                             read_data
);

   localparam int BW = (LANES > 1) ? $clog2(LANES) : 1;

   logic [LANES-1:0][7:0] lane_bytes;

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [BW:0] sum;
      logic [BW:0] idx;
      assign sum = (BW+1)'(rot) + (BW+1)'(j);
      assign idx = (sum >= (BW+1)'(LANES)) ? sum - (BW+1)'(LANES) : sum;
      assign lane_bytes[j] = (LEN_W'(j) < cnt) ? bank_data[idx[BW-1:0]] : 8'd0;
   end

   assign read_data = DATA_W'(lane_bytes);

endmodule

// ----- hdl/byte_ring_buffer_fifo_top.sv -----
// Byte ring buffer with one slot always kept empty.
// req_chan carries one item: action (write, read, peek, query), a length of up
// to LANES bytes and the write bytes. rsp_chan returns one item per request:
// byte count, read bytes and the ring status after the action.
// csr_write_enable with csr_write_data sets the ring size (clamped to 2..DEPTH)
// and empties the ring; write it only while the block is idle.
// Flow: an accepted item goes through the EXEC and MERGE states; its result is
// registered on leaving MERGE, and only then does the block return to IDLE and
// take the next item. This is set by the registered read port of the byte banks:
// index check and bank access happen in EXEC, lane merge and status in MERGE.
// The bytes sit in LANES banks, each one byte wide with DEPTH/LANES rows
// (rounded up), so up to LANES bytes go in or out in one access.
// Reset empties the ring and sets the ring size to 256 (or DEPTH if smaller);
// bank contents are not cleared and need no clearing pass.
// When the receiver stalls, the result is held in the output register and
// req_chan.ready stays low once the next result is ready to be loaded.
`include "assert_macros.svh"

module byte_ring_buffer_fifo_top import brbf_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int LANES = LANES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [RING_CFG_W-1:0] csr_write_data,
   brbf_req_if.sink              req_chan,
   brbf_rsp_if.source            rsp_chan
);

   localparam int ROWS   = (DEPTH + LANES - 1) / LANES;
   localparam int BW     = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RS_W   = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW     = (RS_W > LEN_W) ? RS_W : LEN_W;
   localparam int RING_0 = (RING_RESET > DEPTH) ? DEPTH : RING_RESET;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MERGE
   } state_type;

   state_type             state_ff, state_in;
   action_type            act_ff, act_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LANES-1:0][7:0] wdata_ff, wdata_in;
   logic [RS_W-1:0]       ring_ff, ring_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [BW-1:0]         wb_ff, wb_in;
   logic [RW-1:0]         wr_ff, wr_in;
   logic [BW-1:0]         rb_ff, rb_in;
   logic [RW-1:0]         rr_ff, rr_in;
   logic [LEN_W-1:0]      cnt_ff, cnt_in;
   logic [BW-1:0]         rot_ff, rot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]     rsp_fill_ff, rsp_fill_in;
   logic [STAT_W-1:0]     rsp_free_ff, rsp_free_in;
   logic [STAT_W-1:0]     rsp_rpos_ff, rsp_rpos_in;
   logic [STAT_W-1:0]     rsp_rrun_ff, rsp_rrun_in;
   logic [STAT_W-1:0]     rsp_wpos_ff, rsp_wpos_in;
   logic [STAT_W-1:0]     rsp_wrun_ff, rsp_wrun_in;

   logic [RS_W-1:0]       cfg_ring;
   logic [LEN_W-1:0]      req_len;
   logic [CW-1:0]         fill_x, avail_x;
   logic                  wr_ok, is_rd;
   logic [LEN_W-1:0]      rd_cnt;
   logic [CW:0]           head_sum, tail_sum;
   logic [BW+1:0]         wb_sum, rb_sum;
   logic [CW-1:0]         rrun_m, wrun_m;
   logic [CW-1:0]         to_end_r, to_end_w;
   bank_op_type           bank_op;
   logic [LANES-1:0][7:0] bank_data;
   logic [DATA_W-1:0]     merged;
   logic                  out_free;

   // clamp the configured ring size to 2..DEPTH
   always_comb begin
      if (csr_write_data < RING_CFG_W'(2)) begin
         cfg_ring = RS_W'(2);
      end else if (32'(csr_write_data) > 32'(DEPTH)) begin
         cfg_ring = RS_W'(DEPTH);
      end else begin
         cfg_ring = RS_W'(csr_write_data);
      end
   end

   assign req_len = (req_chan.length > LEN_W'(LANES)) ? LEN_W'(LANES) : req_chan.length;

   assign fill_x  = (head_ff >= tail_ff) ? CW'(head_ff) - CW'(tail_ff)
                                         : CW'(ring_ff) - (CW'(tail_ff) - CW'(head_ff));
   assign avail_x = CW'(ring_ff) - fill_x - 1'b1;
   assign is_rd   = (act_ff == ACT_READ) || (act_ff == ACT_PEEK);
   assign wr_ok   = (act_ff == ACT_WRITE) && (CW'(len_ff) <= avail_x) && (len_ff != '0);
   assign rd_cnt  = (CW'(len_ff) < fill_x) ? len_ff : LEN_W'(fill_x);

   assign head_sum = (CW+1)'(head_ff) + (CW+1)'(len_ff);
   assign tail_sum = (CW+1)'(tail_ff) + (CW+1)'(rd_cnt);
   assign wb_sum   = (BW+2)'(wb_ff) + (BW+2)'(len_ff);
   assign rb_sum   = (BW+2)'(rb_ff) + (BW+2)'(rd_cnt);

   assign to_end_r = CW'(ring_ff) - CW'(tail_ff);
   assign to_end_w = CW'(ring_ff) - CW'(head_ff);
   assign rrun_m   = (to_end_r > fill_x) ? fill_x : to_end_r;
   assign wrun_m   = (to_end_w > avail_x) ? avail_x : to_end_w;

   assign bank_op.wr_en = (state_ff == ST_EXEC) && wr_ok;
   assign bank_op.rd_en = (state_ff == ST_EXEC) && is_rd;

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      brbf_bank #(
         .LANES (LANES),
         .ROWS  (ROWS),
         .BANK  (b)
      ) u_bank (
         .clock   (clock),
         .op      (bank_op),
         .wr_bank (wb_ff),
         .wr_row  (wr_ff),
         .wr_len  (len_ff),
         .wr_data (wdata_ff),
         .rd_bank (rb_ff),
         .rd_row  (rr_ff),
         .rd_data (bank_data[b])
      );
   end

   brbf_merge #(
      .LANES (LANES)
   ) u_merge (
      .bank_data (bank_data),
      .rot       (rot_ff),
      .cnt       (cnt_ff),
      .read_data (merged)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      len_in       = len_ff;
      wdata_in     = wdata_ff;
      ring_in      = ring_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      wb_in        = wb_ff;
      wr_in        = wr_ff;
      rb_in        = rb_ff;
      rr_in        = rr_ff;
      cnt_in       = cnt_ff;
      rot_in       = rot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in = rsp_count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_free_in  = rsp_free_ff;
      rsp_rpos_in  = rsp_rpos_ff;
      rsp_rrun_in  = rsp_rrun_ff;
      rsp_wpos_in  = rsp_wpos_ff;
      rsp_wrun_in  = rsp_wrun_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in   = action_type'(req_chan.action);
               len_in   = req_len;
               wdata_in = req_chan.write_data[LANES*8-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rot_in = rb_ff;
            if (wr_ok) begin
               cnt_in  = len_ff;
               head_in = (head_sum >= (CW+1)'(ring_ff)) ? IDX_W'(head_sum - (CW+1)'(ring_ff))
                                                        : IDX_W'(head_sum);
               if (wb_sum >= (BW+2)'(LANES)) begin
                  wb_in = BW'(wb_sum - (BW+2)'(LANES));
                  wr_in = (wr_ff == RW'(ROWS - 1)) ? '0 : wr_ff + 1'b1;
               end else begin
                  wb_in = BW'(wb_sum);
               end
            end else if (is_rd) begin
               cnt_in = rd_cnt;
            end else begin
               cnt_in = '0;
            end
            if (act_ff == ACT_READ) begin
               tail_in = (tail_sum >= (CW+1)'(ring_ff)) ? IDX_W'(tail_sum - (CW+1)'(ring_ff))
                                                        : IDX_W'(tail_sum);
               if (rb_sum >= (BW+2)'(LANES)) begin
                  rb_in = BW'(rb_sum - (BW+2)'(LANES));
                  rr_in = (rr_ff == RW'(ROWS - 1)) ? '0 : rr_ff + 1'b1;
               end else begin
                  rb_in = BW'(rb_sum);
               end
            end
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               rsp_data_in  = is_rd ? merged : '0;
               rsp_fill_in  = STAT_W'(fill_x);
               rsp_free_in  = STAT_W'(avail_x);
               rsp_rpos_in  = STAT_W'(tail_ff);
               rsp_rrun_in  = STAT_W'(rrun_m);
               rsp_wpos_in  = STAT_W'(head_ff);
               rsp_wrun_in  = STAT_W'(wrun_m);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a ring size write empties the ring
      if (csr_write_enable) begin
         ring_in = cfg_ring;
         head_in = '0;
         tail_in = '0;
         wb_in   = '0;
         wr_in   = '0;
         rb_in   = '0;
         rr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ring_ff      <= RS_W'(RING_0);
         head_ff      <= '0;
         tail_ff      <= '0;
         wb_ff        <= '0;
         wr_ff        <= '0;
         rb_ff        <= '0;
         rr_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_ff      <= ring_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wb_ff        <= wb_in;
         wr_ff        <= wr_in;
         rb_ff        <= rb_in;
         rr_ff        <= rr_in;
      end
      act_ff       <= act_in;
      len_ff       <= len_in;
      wdata_ff     <= wdata_in;
      cnt_ff       <= cnt_in;
      rot_ff       <= rot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_rpos_ff  <= rsp_rpos_in;
      rsp_rrun_ff  <= rsp_rrun_in;
      rsp_wpos_ff  <= rsp_wpos_in;
      rsp_wrun_ff  <= rsp_wrun_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.count          = rsp_count_ff;
   assign rsp_chan.read_data      = rsp_data_ff;
   assign rsp_chan.fill_level     = rsp_fill_ff;
   assign rsp_chan.free_space     = rsp_free_ff;
   assign rsp_chan.read_position  = rsp_rpos_ff;
   assign rsp_chan.read_run       = rsp_rrun_ff;
   assign rsp_chan.write_position = rsp_wpos_ff;
   assign rsp_chan.write_run      = rsp_wrun_ff;

   `ASSERT_ALWAYS(a_head_in_ring, clock, reset, CW'(head_ff) < CW'(ring_ff))
   `ASSERT_ALWAYS(a_tail_in_ring, clock, reset, CW'(tail_ff) < CW'(ring_ff))
   `ASSERT_NEXT(a_accept_exec, clock, reset, req_chan.valid && req_chan.ready, state_ff == ST_EXEC)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, state_ff == ST_MERGE, cnt_ff <= LEN_W'(LANES))

endmodule

// ----- dv/byte_ring_buffer_fifo_checker.sv -----
`timescale 1ns / 100ps

module byte_ring_buffer_fifo_checker import brbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [RING_CFG_W-1:0] csr_write_data,
   brbf_req_if                   req_mon,
   brbf_rsp_if                   rsp_mon,
   output int                    fail_count,
   output int                    pending_results,
   output int                    results_checked
);

   typedef struct {
      logic [LEN_W-1:0]  count;
      logic [DATA_W-1:0] read_data;
      logic [STAT_W-1:0] fill_level;
      logic [STAT_W-1:0] free_space;
      logic [STAT_W-1:0] read_position;
      logic [STAT_W-1:0] read_run;
      logic [STAT_W-1:0] write_position;
      logic [STAT_W-1:0] write_run;
   } ring_status_type;

   logic [7:0]      ring_bytes [DEPTH_DEF];
   int unsigned     head_idx;
   int unsigned     tail_idx;
   int unsigned     ring_len;
   ring_status_type expected_status [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
   end

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      if (fail_count < 40) begin
         $display("MISMATCH result %0d %s: got %0h, want %0h",
                  results_checked, what, got, want);
      end
      fail_count++;
   endtask

   function automatic int unsigned ring_fill();
      if (head_idx >= tail_idx) begin
         return head_idx - tail_idx;
      end
      return ring_len - (tail_idx - head_idx);
   endfunction

   function automatic ring_status_type apply_access(action_type act,
                                                    logic [LEN_W-1:0] req_len,
                                                    logic [DATA_W-1:0] data);
      int unsigned     len;
      int unsigned     fill;
      int unsigned     room;
      int unsigned     n;
      int unsigned     run;
      ring_status_type res;
      res = '{default: '0};
      len = (req_len > LANES_DEF) ? LANES_DEF : req_len;
      fill = ring_fill();
      room = ring_len - fill - 1;
      case (act)
         ACT_WRITE: begin
            if (len <= room) begin
               for (int i = 0; i < len; i++) begin
                  ring_bytes[(head_idx + i) % ring_len] = data[8*i +: 8];
               end
               head_idx  = (head_idx + len) % ring_len;
               res.count = len[LEN_W-1:0];
            end
         end
         ACT_READ, ACT_PEEK: begin
            n = (len < fill) ? len : fill;
            for (int i = 0; i < n; i++) begin
               res.read_data[8*i +: 8] = ring_bytes[(tail_idx + i) % ring_len];
            end
            if (act == ACT_READ) begin
               tail_idx = (tail_idx + n) % ring_len;
            end
            res.count = n[LEN_W-1:0];
         end
         default: ;
      endcase
      fill = ring_fill();
      room = ring_len - fill - 1;
      res.fill_level     = fill[STAT_W-1:0];
      res.free_space     = room[STAT_W-1:0];
      res.read_position  = tail_idx[STAT_W-1:0];
      res.write_position = head_idx[STAT_W-1:0];
      run = ring_len - tail_idx;
      if (run > fill) begin
         run = fill;
      end
      res.read_run = run[STAT_W-1:0];
      run = ring_len - head_idx;
      if (run > room) begin
         run = room;
      end
      res.write_run = run[STAT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      ring_status_type want;
      int unsigned     new_len;
      if (reset) begin
         head_idx = 0;
         tail_idx = 0;
         ring_len = (RING_RESET > DEPTH_DEF) ? DEPTH_DEF : RING_RESET;
         expected_status.delete();
         pending_results <= 0;
      end else begin
         if (csr_write_enable) begin
            new_len = csr_write_data;
            if (new_len < 2) begin
               new_len = 2;
            end
            if (new_len > DEPTH_DEF) begin
               new_len = DEPTH_DEF;
            end
            ring_len = new_len;
            head_idx = 0;
            tail_idx = 0;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_status.push_back(apply_access(action_type'(req_mon.action),
                                                   req_mon.length, req_mon.write_data));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_status.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_mon.count, '0);
            end else begin
               want = expected_status.pop_front();
               if (rsp_mon.count !== want.count) begin
                  report_mismatch("count", rsp_mon.count, want.count);
               end
               if (rsp_mon.read_data !== want.read_data) begin
                  report_mismatch("read_data", rsp_mon.read_data, want.read_data);
               end
               if (rsp_mon.fill_level !== want.fill_level) begin
                  report_mismatch("fill_level", rsp_mon.fill_level, want.fill_level);
               end
               if (rsp_mon.free_space !== want.free_space) begin
                  report_mismatch("free_space", rsp_mon.free_space, want.free_space);
               end
               if (rsp_mon.read_position !== want.read_position) begin
                  report_mismatch("read_position", rsp_mon.read_position,
                                  want.read_position);
               end
               if (rsp_mon.read_run !== want.read_run) begin
                  report_mismatch("read_run", rsp_mon.read_run, want.read_run);
               end
               if (rsp_mon.write_position !== want.write_position) begin
                  report_mismatch("write_position", rsp_mon.write_position,
                                  want.write_position);
               end
               if (rsp_mon.write_run !== want.write_run) begin
                  report_mismatch("write_run", rsp_mon.write_run, want.write_run);
               end
            end
            results_checked <= results_checked + 1;
         end
         pending_results <= expected_status.size();
      end
   end

endmodule

// ----- dv/byte_ring_buffer_fifo_top_tb.sv -----
`timescale 1ns / 100ps

module byte_ring_buffer_fifo_top_tb;
   import brbf_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 13;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [RING_CFG_W-1:0] csr_write_data;

   int fail_count;
   int pending_results;
   int results_checked;
   int send_idle_pct;
   int stall_pct;
   int items_sent;
   int ring_writes;
   int cycle_count;
   int hold_left;
   bit hold_req;
   bit hold_ack;

   logic [RING_CFG_W-1:0] ring_plan [PHASES] = '{
      9'd256, 9'd2, 9'd3, 9'd5, 9'd8, 9'd9, 9'd16,
      9'd100, 9'd255, 9'd0, 9'd511, 9'd1, 9'd64
   };

   brbf_req_if req_chan ();
   brbf_rsp_if rsp_chan ();

   byte_ring_buffer_fifo_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   byte_ring_buffer_fifo_checker u_ring_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results pending",
                  cycle_count, pending_results);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // hold the result channel off for a long stretch on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack       <= hold_req;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(action_type act, logic [LEN_W-1:0] len,
                            logic [DATA_W-1:0] data);
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.length     <= len;
      req_chan.write_data <= data;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_ring(logic [RING_CFG_W-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ring_writes++;
      @(posedge clock);
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct    <= 0;
         end
         IDLE_SEND: begin
            send_idle_pct = 83;
            stall_pct    <= 0;
         end
         IDLE_STALL: begin
            send_idle_pct = 0;
            stall_pct    <= 83;
         end
         default: begin
            send_idle_pct = 30;
            stall_pct    <= 30;
         end
      endcase
   endtask

   // alternate filling and draining runs so the ring swings between full and empty
   task automatic random_items(int n);
      int         pick;
      int         run_left;
      bit         filling;
      action_type act;
      logic [LEN_W-1:0] len;
      run_left = 0;
      filling  = 1'($urandom_range(1));
      repeat (n) begin
         if (run_left == 0) begin
            filling  = ~filling;
            run_left = $urandom_range(40, 6);
         end
         run_left--;
         pick = $urandom_range(99);
         if (filling) begin
            act = (pick < 60) ? ACT_WRITE : (pick < 80) ? ACT_READ :
                  (pick < 92) ? ACT_PEEK : ACT_QUERY;
         end else begin
            act = (pick < 20) ? ACT_WRITE : (pick < 75) ? ACT_READ :
                  (pick < 90) ? ACT_PEEK : ACT_QUERY;
         end
         pick = $urandom_range(99);
         if (pick < 6) begin
            len = '0;
         end else if (pick < 12) begin
            len = LEN_W'($urandom_range(15, LANES_DEF + 1));
         end else begin
            len = LEN_W'($urandom_range(LANES_DEF, 1));
         end
         send_item(act, len, {$urandom, $urandom});
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_chan.valid      = 1'b0;
      req_chan.action     = ACT_QUERY;
      req_chan.length     = '0;
      req_chan.write_data = '0;
      rsp_chan.ready      = 1'b0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      items_sent          = 0;
      ring_writes         = 0;
      cycle_count         = 0;
      hold_left           = 0;
      hold_req            = 1'b0;
      hold_ack            = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_QUERY, 4'd0, '0);
      send_item(ACT_READ, 4'd8, '0);
      send_item(ACT_PEEK, 4'd15, '1);
      send_item(ACT_WRITE, 4'd0, '1);
      send_item(ACT_WRITE, 4'd8, '1);
      send_item(ACT_WRITE, 4'd15, '0);
      send_item(ACT_WRITE, 4'd9, 64'h0123_4567_89AB_CDEF);
      send_item(ACT_PEEK, 4'd15, '0);
      send_item(ACT_READ, 4'd3, '0);
      send_item(ACT_READ, 4'd0, '0);
      send_item(ACT_READ, 4'd12, '0);
      send_item(ACT_READ, 4'd15, '0);
      send_item(ACT_READ, 4'd8, '0);
      drain();
      set_ring(9'd0);
      send_item(ACT_WRITE, 4'd2, '1);
      send_item(ACT_WRITE, 4'd1, 64'hA5);
      send_item(ACT_WRITE, 4'd1, 64'h5A);
      send_item(ACT_PEEK, 4'd8, '0);
      send_item(ACT_READ, 4'd8, '0);
      send_item(ACT_WRITE, 4'd1, 64'h3C);
      send_item(ACT_READ, 4'd2, '0);
      drain();
      set_ring(9'd1);
      set_ring(9'd9);
      send_item(ACT_WRITE, 4'd8, '1);
      send_item(ACT_WRITE, 4'd1, '0);
      send_item(ACT_QUERY, 4'd15, '1);
      drain();
      // rewriting the size must empty a non-empty ring
      set_ring(9'd300);
      send_item(ACT_READ, 4'd8, '0);
      send_item(ACT_QUERY, 4'd0, '0);

      drain();
      set_idling(IDLE_NONE);
      hold_req <= ~hold_req;
      random_items(60);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         drain();
         set_ring((p == PHASES - 1) ? RING_CFG_W'($urandom_range(DEPTH_DEF, 2)) :
                  ring_plan[p]);
         set_idling(idle_mode_type'(p % 4));
         random_items(80);
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d items and checked %0d results across %0d ring size writes,",
               items_sent, results_checked, ring_writes);
      $display("with refused writes, wraps, full and empty rings and a long result stall");
      if (fail_count == 0 && pending_results == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/brbf_pkg.sv
hdl/brbf_if.sv
hdl/brbf_bank.sv
hdl/brbf_merge.sv
hdl/byte_ring_buffer_fifo_top.sv
dv/byte_ring_buffer_fifo_checker.sv
dv/byte_ring_buffer_fifo_top_tb.sv
